>>> rtl/core/stpc_pkg.sv
// Shared types and constants for the sensor temperature/pressure compensation block.
// Depends on nothing; the front, queue, back and top-level files use it by scoped names.
`timescale 1ns / 1ps

package stpc_pkg;

   typedef logic signed [31:0] s32_type;

   // Calibration words as held in the configuration registers
   typedef struct packed {
      logic [15:0] t1;
      logic [15:0] t2;
      logic [15:0] t3;
      logic [15:0] p1;
      logic [15:0] p2;
      logic [15:0] p3;
      logic [15:0] p4;
      logic [15:0] p5;
      logic [15:0] p6;
      logic [15:0] p7;
      logic [15:0] p8;
      logic [15:0] p9;
   } cal_type;

   // Beat passed from the front pipeline to the divide/finish engine
   typedef struct packed {
      s32_type     temperature;
      logic [31:0] divisor;
      logic [31:0] numerator;
   } job_type;

   // Configuration register indexes
   localparam logic [1:0] REG_CAL_TEMPERATURE    = 2'd0;
   localparam logic [1:0] REG_CAL_PRESSURE_LOW   = 2'd1;
   localparam logic [1:0] REG_CAL_PRESSURE_HIGH  = 2'd2;
   localparam logic [1:0] REG_CAL_PRESSURE_NINTH = 2'd3;

   localparam s32_type PRESS_OFFSET = 32'sd64000;
   localparam s32_type PRESS_FULL   = 32'sd1048576;
   localparam s32_type PRESS_SCALE  = 32'sd3125;
   localparam s32_type DIV_BIAS     = 32'sd32768;
   localparam s32_type TEMP_ROUND   = 32'sd128;

   localparam int QUEUE_DEPTH = 2;

   // Wrapping 32-bit multiply: low word of the product
   function automatic s32_type mul32(input s32_type a, input s32_type b);
      logic [63:0] prod;
      prod = 64'(unsigned'(a)) * 64'(unsigned'(b));
      return s32_type'(prod[31:0]);
   endfunction

   // Sign-extend a 16-bit calibration word
   function automatic s32_type sx16(input logic [15:0] v);
      return s32_type'({{16{v[15]}}, v});
   endfunction

   // Zero-extend a 16-bit calibration word
   function automatic s32_type zx16(input logic [15:0] v);
      return s32_type'({16'd0, v});
   endfunction

endpackage

>>> rtl/core/stpc_req_if.sv
// Input channel of the compensation block: valid/ready plus the two raw readings.
// Depends on nothing.
`timescale 1ns / 1ps

interface stpc_req_if;
   logic        valid;
   logic        ready;
   logic [19:0] raw_temperature;
   logic [19:0] raw_pressure;

   modport source (output valid, output raw_temperature, output raw_pressure, input ready);
   modport sink (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

>>> rtl/core/stpc_rsp_if.sv
// Result channel of the compensation block: valid/ready plus the compensated values.
// Depends on nothing.
`timescale 1ns / 1ps

interface stpc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] temperature_centi;
   logic        [31:0] pressure_q24_8;
   logic               divisor_zero;

   modport source (output valid, output temperature_centi, output pressure_q24_8,
                   output divisor_zero, input ready);
   modport sink (input valid, input temperature_centi, input pressure_q24_8,
                 input divisor_zero, output ready);
endinterface

>>> rtl/core/stpc_front.sv
// Front pipeline: ten stages, at most one multiply level each, from raw readings to
// temperature, pressure divisor and pressure numerator. Depends on stpc_pkg.
`timescale 1ns / 1ps

module stpc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  stpc_pkg::cal_type    cal,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [19:0]          in_raw_temperature,
   input  logic [19:0]          in_raw_pressure,
   output logic                 out_valid,
   input  logic                 out_ready,
   output stpc_pkg::job_type    out_job
);

   localparam int STAGES = 10;

   logic [STAGES-1:0] vld_ff, vld_in;
   logic              en;

   stpc_pkg::s32_type x1_ff, x1_in, d_ff, d_in;
   stpc_pkg::s32_type m1_ff, m1_in, m2_ff, m2_in;
   stpc_pkg::s32_type at_ff, at_in, m3_ff, m3_in;
   stpc_pkg::s32_type fine_ff, fine_in;
   stpc_pkg::s32_type temp5_ff, temp5_in, pa_ff, pa_in;
   stpc_pkg::s32_type sq_ff, sq_in, m5_ff, m5_in, m6_ff, m6_in;
   stpc_pkg::s32_type b7_ff, b7_in, m7_ff, m7_in, m5b_ff, m6b_ff;
   stpc_pkg::s32_type b8_ff, b8_in, a8_ff, a8_in;
   stpc_pkg::s32_type m9_ff, m9_in, n9_ff, n9_in;
   stpc_pkg::s32_type div_ff, div_in, pn_ff, pn_in;
   stpc_pkg::s32_type temp_ff [6:STAGES];
   logic [19:0]       up_ff [1:8];

   stpc_pkg::s32_type ut32, up32, pa4;

   // Advance the whole pipe unless the last stage is blocked
   assign en        = !vld_ff[STAGES-1] || out_ready;
   assign in_ready  = en;
   assign out_valid = vld_ff[STAGES-1];
   assign vld_in    = {vld_ff[STAGES-2:0], in_valid};

   always_comb begin
      ut32    = stpc_pkg::s32_type'({12'd0, in_raw_temperature});
      up32    = stpc_pkg::s32_type'({12'd0, up_ff[8]});
      pa4     = pa_ff >>> 2;
      x1_in   = (ut32 >>> 3) - (stpc_pkg::zx16(cal.t1) <<< 1);
      d_in    = (ut32 >>> 4) - stpc_pkg::zx16(cal.t1);
      m1_in   = stpc_pkg::mul32(x1_ff, stpc_pkg::sx16(cal.t2));
      m2_in   = stpc_pkg::mul32(d_ff, d_ff);
      at_in   = m1_ff >>> 11;
      m3_in   = stpc_pkg::mul32(m2_ff >>> 12, stpc_pkg::sx16(cal.t3));
      fine_in = at_ff + (m3_ff >>> 14);
      temp5_in = ((fine_ff <<< 2) + fine_ff + stpc_pkg::TEMP_ROUND) >>> 8;
      pa_in   = (fine_ff >>> 1) - stpc_pkg::PRESS_OFFSET;
      sq_in   = stpc_pkg::mul32(pa4, pa4);
      m5_in   = stpc_pkg::mul32(pa_ff, stpc_pkg::sx16(cal.p5));
      m6_in   = stpc_pkg::mul32(stpc_pkg::sx16(cal.p2), pa_ff);
      b7_in   = stpc_pkg::mul32(sq_ff >>> 11, stpc_pkg::sx16(cal.p6));
      m7_in   = stpc_pkg::mul32(stpc_pkg::sx16(cal.p3), sq_ff >>> 13);
      b8_in   = ((b7_ff + (m5b_ff <<< 1)) >>> 2) + (stpc_pkg::sx16(cal.p4) <<< 16);
      a8_in   = ((m7_ff >>> 3) + (m6b_ff >>> 1)) >>> 18;
      m9_in   = stpc_pkg::mul32(stpc_pkg::DIV_BIAS + a8_ff, stpc_pkg::zx16(cal.p1));
      n9_in   = (stpc_pkg::PRESS_FULL - up32) - (b8_ff >>> 12);
      div_in  = m9_ff >>> 15;
      pn_in   = stpc_pkg::mul32(n9_ff, stpc_pkg::PRESS_SCALE);
   end

   // Clear valid bits under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // Advance payload one stage per enabled cycle
   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff   <= x1_in;
         d_ff    <= d_in;
         m1_ff   <= m1_in;
         m2_ff   <= m2_in;
         at_ff   <= at_in;
         m3_ff   <= m3_in;
         fine_ff <= fine_in;
         temp5_ff <= temp5_in;
         pa_ff   <= pa_in;
         sq_ff   <= sq_in;
         m5_ff   <= m5_in;
         m6_ff   <= m6_in;
         b7_ff   <= b7_in;
         m7_ff   <= m7_in;
         m5b_ff  <= m5_ff;
         m6b_ff  <= m6_ff;
         b8_ff   <= b8_in;
         a8_ff   <= a8_in;
         m9_ff   <= m9_in;
         n9_ff   <= n9_in;
         div_ff  <= div_in;
         pn_ff   <= pn_in;
         temp_ff[6] <= temp5_ff;
         for (int i = 7; i <= STAGES; i++) begin
            temp_ff[i] <= temp_ff[i-1];
         end
         up_ff[1] <= in_raw_pressure;
         for (int i = 2; i <= 8; i++) begin
            up_ff[i] <= up_ff[i-1];
         end
      end
   end

   assign out_job.temperature = temp_ff[STAGES];
   assign out_job.divisor     = unsigned'(div_ff);
   assign out_job.numerator   = unsigned'(pn_ff);

endmodule

>>> rtl/core/stpc_queue.sv
// Two-entry queue of jobs between the front pipeline and the back engine.
// Depends on stpc_pkg.
`timescale 1ns / 1ps

module stpc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  stpc_pkg::job_type push_job,
   output logic              pop_valid,
   input  logic              pop_ready,
   output stpc_pkg::job_type pop_job
);

   localparam int PW = $clog2(stpc_pkg::QUEUE_DEPTH);

   stpc_pkg::job_type mem_ff [stpc_pkg::QUEUE_DEPTH];
   logic [PW-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]       cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign push_ready = cnt_ff != (PW+1)'(stpc_pkg::QUEUE_DEPTH);
   assign pop_valid  = cnt_ff != '0;
   assign pop_job    = mem_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_in  = do_push ? PW'((wr_ff + 1'b1) % stpc_pkg::QUEUE_DEPTH) : wr_ff;
      rd_in  = do_pop  ? PW'((rd_ff + 1'b1) % stpc_pkg::QUEUE_DEPTH) : rd_ff;
      cnt_in = cnt_ff + (PW+1)'(do_push) - (PW+1)'(do_pop);
   end

   // Track pointers and fill
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store the pushed beat
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end

endmodule

>>> rtl/core/stpc_back.sv
// Back engine: bit-serial unsigned divide, then the three-multiply pressure
// correction and the output register. Depends on stpc_pkg.
`timescale 1ns / 1ps

module stpc_back (
   input  logic               clock,
   input  logic               reset,
   input  stpc_pkg::cal_type  cal,
   input  logic               job_valid,
   output logic               job_ready,
   input  stpc_pkg::job_type  job,
   output logic               out_valid,
   input  logic               out_ready,
   output logic signed [31:0] out_temperature_centi,
   output logic [31:0]        out_pressure_q24_8,
   output logic               out_divisor_zero
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIV, ST_QUOT, ST_MUL, ST_SHIFT, ST_SUM, ST_HOLD
   } state_type;

   state_type         state_ff;
   logic              vld_ff;
   stpc_pkg::s32_type temp_ff, otemp_ff;
   logic [31:0]       div_ff, dvd_ff, rem_ff, pp_ff, pres_ff, opres_ff;
   logic              hi_ff, dz_ff, odz_ff;
   logic [4:0]        cnt_ff;
   stpc_pkg::s32_type s_ff, mb_ff, pa_ff, pb_ff;

   logic [32:0]       trial;
   logic              ge;
   logic [31:0]       rem_in, dvd_in, pres_in;

   assign job_ready = state_ff == ST_IDLE;

   // One restoring divide step and the final sum
   always_comb begin
      trial   = {rem_ff, dvd_ff[31]};
      ge      = trial >= {1'b0, div_ff};
      rem_in  = ge ? 32'(trial - {1'b0, div_ff}) : trial[31:0];
      dvd_in  = {dvd_ff[30:0], ge};
      pres_in = 32'(pp_ff + unsigned'((pa_ff + pb_ff + stpc_pkg::sx16(cal.p7)) >>> 4)) << 8;
   end

   // Sequence one job and hold the result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         vld_ff   <= 1'b0;
      end else begin
         if (vld_ff && out_ready && state_ff != ST_HOLD) begin
            vld_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (job_valid) begin
                  temp_ff <= job.temperature;
                  div_ff  <= job.divisor;
                  hi_ff   <= job.numerator[31];
                  dvd_ff  <= job.numerator[31] ? job.numerator : job.numerator << 1;
                  rem_ff  <= '0;
                  cnt_ff  <= '0;
                  if (job.divisor == '0) begin
                     pres_ff  <= '0;
                     dz_ff    <= 1'b1;
                     state_ff <= ST_HOLD;
                  end else begin
                     dz_ff    <= 1'b0;
                     state_ff <= ST_DIV;
                  end
               end
            end
            ST_DIV: begin
               rem_ff <= rem_in;
               dvd_ff <= dvd_in;
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd31) begin
                  state_ff <= ST_QUOT;
               end
            end
            ST_QUOT: begin
               pp_ff    <= hi_ff ? dvd_ff << 1 : dvd_ff;
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               s_ff     <= stpc_pkg::mul32(signed'(pp_ff >> 3), signed'(pp_ff >> 3));
               mb_ff    <= stpc_pkg::mul32(signed'(pp_ff >> 2), stpc_pkg::sx16(cal.p8));
               state_ff <= ST_SHIFT;
            end
            ST_SHIFT: begin
               pa_ff    <= stpc_pkg::mul32(stpc_pkg::sx16(cal.p9),
                                           signed'(unsigned'(s_ff) >> 13)) >>> 12;
               pb_ff    <= mb_ff >>> 13;
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               pres_ff  <= pres_in;
               state_ff <= ST_HOLD;
            end
            ST_HOLD: begin
               if (!vld_ff || out_ready) begin
                  vld_ff   <= 1'b1;
                  otemp_ff <= temp_ff;
                  opres_ff <= pres_ff;
                  odz_ff   <= dz_ff;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign out_valid             = vld_ff;
   assign out_temperature_centi = otemp_ff;
   assign out_pressure_q24_8    = opres_ff;
   assign out_divisor_zero      = odz_ff;

endmodule

>>> rtl/core/sensor_temp_pressure_compensation.sv
// Top level of the temperature/pressure compensation block: calibration
// registers, front pipeline, job queue and back engine. Depends on stpc_pkg,
// stpc_req_if, stpc_rsp_if, stpc_front, stpc_queue and stpc_back.
//
//   channel   dir   handshake          beat
//   req       in    valid/ready        raw_temperature, raw_pressure
//   rsp       out   valid/ready        temperature_centi, pressure_q24_8, divisor_zero
//   csr       in    csr_write_enable   csr_index, csr_write_data (64 bits)
//
// The front pipeline takes one beat per cycle while its last stage is not blocked.
// The back engine takes a new item only when done with the last: the bit-serial
// divider, then the pressure correction, or straight out on a zero divisor; it sets the sustained rate.
// Reset is synchronous and clears calibration to zero. A stalled rsp backs up
// into the queue, then the front.
`timescale 1ns / 1ps

module sensor_temp_pressure_compensation (
   input  logic        clock,
   input  logic        reset,
   stpc_req_if.sink    req_if,
   stpc_rsp_if.source  rsp_if,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_write_data
);

   logic [47:0] cal_t_ff;
   logic [63:0] cal_pl_ff, cal_ph_ff;
   logic [15:0] cal_p9_ff;
   stpc_pkg::cal_type cal;

   logic              fq_valid, fq_ready, qb_valid, qb_ready;
   stpc_pkg::job_type fq_job, qb_job;

   // Write calibration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_t_ff  <= '0;
         cal_pl_ff <= '0;
         cal_ph_ff <= '0;
         cal_p9_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            stpc_pkg::REG_CAL_TEMPERATURE:    cal_t_ff  <= csr_write_data[47:0];
            stpc_pkg::REG_CAL_PRESSURE_LOW:   cal_pl_ff <= csr_write_data;
            stpc_pkg::REG_CAL_PRESSURE_HIGH:  cal_ph_ff <= csr_write_data;
            stpc_pkg::REG_CAL_PRESSURE_NINTH: cal_p9_ff <= csr_write_data[15:0];
            default: begin
            end
         endcase
      end
   end

   assign cal = '{t1: cal_t_ff[15:0],  t2: cal_t_ff[31:16],  t3: cal_t_ff[47:32],
                  p1: cal_pl_ff[15:0], p2: cal_pl_ff[31:16], p3: cal_pl_ff[47:32],
                  p4: cal_pl_ff[63:48], p5: cal_ph_ff[15:0], p6: cal_ph_ff[31:16],
                  p7: cal_ph_ff[47:32], p8: cal_ph_ff[63:48], p9: cal_p9_ff};

   stpc_front u_front (
      .clock              (clock),
      .reset              (reset),
      .cal                (cal),
      .in_valid           (req_if.valid),
      .in_ready           (req_if.ready),
      .in_raw_temperature (req_if.raw_temperature),
      .in_raw_pressure    (req_if.raw_pressure),
      .out_valid          (fq_valid),
      .out_ready          (fq_ready),
      .out_job            (fq_job)
   );

   stpc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_job   (fq_job),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_job    (qb_job)
   );

   stpc_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .cal                   (cal),
      .job_valid             (qb_valid),
      .job_ready             (qb_ready),
      .job                   (qb_job),
      .out_valid             (rsp_if.valid),
      .out_ready             (rsp_if.ready),
      .out_temperature_centi (rsp_if.temperature_centi),
      .out_pressure_q24_8    (rsp_if.pressure_q24_8),
      .out_divisor_zero      (rsp_if.divisor_zero)
   );

`ifndef SYNTHESIS
   // A zero-divisor result carries zero pressure
   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.divisor_zero |-> rsp_if.pressure_q24_8 == '0)
      else $error("divisor_zero result with nonzero pressure");

   // Nothing is offered right after reset
   assert property (@(posedge clock) reset |=> !rsp_if.valid)
      else $error("result valid right after reset");

   // The front holds its beat steady while the queue is full
   assert property (@(posedge clock) disable iff (reset)
      fq_valid && !fq_ready |=> fq_valid && $stable(fq_job))
      else $error("front beat lost while queue full");
`endif

endmodule

>>> sim/tb_top.sv
// Testbench for sensor_temp_pressure_compensation: integer compensation checked per beat.
// Depends on stpc_pkg, stpc_req_if, stpc_rsp_if and the block's RTL.
`timescale 1ns / 1ps

module tb_top;

   typedef struct packed {
      logic [19:0] raw_temperature;
      logic [19:0] raw_pressure;
   } reading_type;

   typedef struct packed {
      logic [31:0] temperature_centi;
      logic [31:0] pressure_q24_8;
      logic        divisor_zero;
   } compensated_type;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 80;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [1:0]  csr_index;
   logic [63:0] csr_write_data;

   stpc_req_if req_ch ();
   stpc_rsp_if rsp_ch ();

   sensor_temp_pressure_compensation u_top (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_ch),
      .rsp_if           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Calibration shadow, updated on every register write
   logic [47:0] shadow_temperature;
   logic [63:0] shadow_pressure_low;
   logic [63:0] shadow_pressure_high;
   logic [15:0] shadow_pressure_ninth;

   reading_type     pending_readings[$];
   compensated_type awaited_results[$];
   int              fail_count;
   int              idle_cycles;

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic logic [31:0] asr(input logic [31:0] x, input int n);
      return $unsigned($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] wmul(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] r;
      r = a * b;
      return r;
   endfunction

   function automatic logic [31:0] sext(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   // Compute temperature and pressure from one reading with the current calibration
   function automatic compensated_type compensate(input reading_type rd);
      logic [31:0] ut, up, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [31:0] a, b, d, sq, fine, temp, p;
      compensated_type res;
      ut = {12'd0, rd.raw_temperature};
      up = {12'd0, rd.raw_pressure};
      t1 = {16'd0, shadow_temperature[15:0]};
      t2 = sext(shadow_temperature[31:16]);
      t3 = sext(shadow_temperature[47:32]);
      p1 = {16'd0, shadow_pressure_low[15:0]};
      p2 = sext(shadow_pressure_low[31:16]);
      p3 = sext(shadow_pressure_low[47:32]);
      p4 = sext(shadow_pressure_low[63:48]);
      p5 = sext(shadow_pressure_high[15:0]);
      p6 = sext(shadow_pressure_high[31:16]);
      p7 = sext(shadow_pressure_high[47:32]);
      p8 = sext(shadow_pressure_high[63:48]);
      p9 = sext(shadow_pressure_ninth);
      // temperature and fine value
      a = asr(wmul((ut >> 3) - (t1 << 1), t2), 11);
      d = (ut >> 4) - t1;
      b = asr(wmul(asr(wmul(d, d), 12), t3), 14);
      fine = a + b;
      temp = asr(wmul(fine, 32'd5) + 32'd128, 8);
      // pressure divisor and offset
      a = asr(fine, 1) - 32'd64000;
      sq = wmul(asr(a, 2), asr(a, 2));
      b = wmul(asr(sq, 11), p6);
      b = b + (wmul(a, p5) << 1);
      b = asr(b, 2) + (p4 << 16);
      a = asr(asr(wmul(p3, asr(sq, 13)), 3) + asr(wmul(p2, a), 1), 18);
      a = asr(wmul(32'd32768 + a, p1), 15);
      res.temperature_centi = temp;
      if (a == 32'd0) begin
         res.pressure_q24_8 = 32'd0;
         res.divisor_zero   = 1'b1;
      end else begin
         p = wmul((32'd1048576 - up) - asr(b, 12), 32'd3125);
         if (p < 32'h8000_0000) begin
            p = (p << 1) / a;
         end else begin
            p = (p / a) << 1;
         end
         a = asr(wmul(p9, wmul(p >> 3, p >> 3) >> 13), 12);
         b = asr(wmul(p >> 2, p8), 13);
         p = p + asr(a + b + p7, 4);
         res.pressure_q24_8 = p << 8;
         res.divisor_zero   = 1'b0;
      end
      return res;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", field, got, want, $realtime);
      fail_count++;
   endtask

   // Driver: bursts of beats separated by random gaps
   int burst_left;
   int gap_left;
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         burst_left   <= 0;
         gap_left     <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            awaited_results.push_back(compensate({req_ch.raw_temperature, req_ch.raw_pressure}));
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0) begin
               gap_left     <= gap_left - 1;
               req_ch.valid <= 1'b0;
            end else if (pending_readings.size() > 0) begin
               reading_type rd;
               rd = pending_readings.pop_front();
               req_ch.raw_temperature <= rd.raw_temperature;
               req_ch.raw_pressure    <= rd.raw_pressure;
               req_ch.valid           <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 12);
                  gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: stall on a pattern, check each result beat against the oldest expectation
   int stall_left;
   int run_left;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= 0;
         run_left     <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_results.size() == 0) begin
               $display("unexpected result beat at %0t", $realtime);
               fail_count++;
            end else begin
               compensated_type want;
               want = awaited_results.pop_front();
               if (rsp_ch.temperature_centi !== want.temperature_centi)
                  report_mismatch("temperature_centi", rsp_ch.temperature_centi,
                                  want.temperature_centi);
               if (rsp_ch.pressure_q24_8 !== want.pressure_q24_8)
                  report_mismatch("pressure_q24_8", rsp_ch.pressure_q24_8,
                                  want.pressure_q24_8);
               if (rsp_ch.divisor_zero !== want.divisor_zero)
                  report_mismatch("divisor_zero", {31'd0, rsp_ch.divisor_zero},
                                  {31'd0, want.divisor_zero});
            end
         end
         if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            rsp_ch.ready <= 1'b0;
         end else if (run_left > 0) begin
            run_left     <= run_left - 1;
            rsp_ch.ready <= 1'b1;
         end else begin
            run_left     <= $urandom_range(1, 60);
            stall_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 70);
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Watchdog: count cycles with work outstanding but no beat moving
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (pending_readings.size() == 0 && awaited_results.size() == 0 && !req_ch.valid)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[sensor_temp_pressure_compensation] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic write_cal(input logic [1:0] idx, input logic [63:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      case (idx)
         stpc_pkg::REG_CAL_TEMPERATURE:    shadow_temperature    = data[47:0];
         stpc_pkg::REG_CAL_PRESSURE_LOW:   shadow_pressure_low   = data;
         stpc_pkg::REG_CAL_PRESSURE_HIGH:  shadow_pressure_high  = data;
         stpc_pkg::REG_CAL_PRESSURE_NINTH: shadow_pressure_ninth = data[15:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic load_cal(input logic [63:0] tcal, input logic [63:0] plow,
                           input logic [63:0] phigh, input logic [63:0] p9);
      write_cal(stpc_pkg::REG_CAL_TEMPERATURE, tcal);
      write_cal(stpc_pkg::REG_CAL_PRESSURE_LOW, plow);
      write_cal(stpc_pkg::REG_CAL_PRESSURE_HIGH, phigh);
      write_cal(stpc_pkg::REG_CAL_PRESSURE_NINTH, p9);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Queue readings: mostly near the sensor's working range, some anywhere
   task automatic queue_random(input int count);
      reading_type rd;
      repeat (count) begin
         if ($urandom_range(0, 3) != 0) begin
            rd.raw_temperature = 20'($urandom_range(380000, 620000));
            rd.raw_pressure    = 20'($urandom_range(200000, 500000));
         end else begin
            rd.raw_temperature = 20'($urandom);
            rd.raw_pressure    = 20'($urandom);
         end
         pending_readings.push_back(rd);
      end
   endtask

   task automatic queue_directed();
      logic [19:0] corner[6];
      corner = '{20'h00000, 20'hFFFFF, 20'h80000, 20'h7FFFF, 20'd519888, 20'd415148};
      foreach (corner[i]) begin
         pending_readings.push_back({corner[i], corner[(i + 1) % 6]});
         pending_readings.push_back({corner[i], corner[i]});
      end
   endtask

   // Wait for all beats to drain, then let the pipeline settle
   task automatic drain();
      while (pending_readings.size() > 0 || awaited_results.size() > 0 || req_ch.valid)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      fail_count            = 0;
      idle_cycles           = 0;
      shadow_temperature    = '0;
      shadow_pressure_low   = '0;
      shadow_pressure_high  = '0;
      shadow_pressure_ninth = '0;
      reset                 = 1'b1;
      csr_write_enable      = 1'b0;
      csr_index             = stpc_pkg::REG_CAL_TEMPERATURE;
      csr_write_data        = '0;
      req_ch.valid           = 1'b0;
      req_ch.raw_temperature = '0;
      req_ch.raw_pressure    = '0;
      rsp_ch.ready           = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset calibration: all zero, divisor is zero
      queue_directed();
      drain();

      // Typical factory calibration, high bits of narrow registers set to be dropped
      load_cal({16'hABCD, 16'hFC18, 16'd26435, 16'd27504},
               {16'd2855, 16'd3024, 16'hD643, 16'd36477},
               {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140},
               {48'hFFFF_1234_5678, 16'd6000});
      queue_directed();
      queue_random(350);
      drain();

      // Extremes: most negative coefficients, largest unsigned
      load_cal(64'h0000_8000_8000_FFFF, 64'h8000_8000_8000_FFFF,
               64'h8000_8000_8000_8000, 64'h8000);
      queue_directed();
      queue_random(80);
      drain();

      // Extremes: most positive coefficients
      load_cal(64'h0000_7FFF_7FFF_0000, 64'h7FFF_7FFF_7FFF_0001,
               64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF);
      queue_random(80);
      drain();

      // All ones everywhere
      load_cal('1, '1, '1, '1);
      queue_random(60);
      drain();

      // Zero divisor with otherwise random calibration
      load_cal(rand64(), rand64() & 64'hFFFF_FFFF_FFFF_0000, rand64(), rand64());
      queue_random(40);
      drain();

      // Fully random calibration sets
      repeat (4) begin
         load_cal(rand64(), rand64(), rand64(), rand64());
         queue_random(60);
         drain();
      end

      if (fail_count == 0) begin
         $display("[sensor_temp_pressure_compensation] OK");
      end else begin
         $display("[sensor_temp_pressure_compensation] ERROR");
      end
      $finish;
   end

endmodule
